[rtl/core/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// lsc_pkg
// Widths and types shared by the 3x3 Cramer's rule solver.
// ----------------------------------------------------------------------------
`default_nettype none
package lsc_pkg;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int THR_W     = 31;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CF_W      = 2 * DATA_W + 1;
  localparam int PART_W    = 2 * DATA_W + 1;
  localparam int TERM_W    = 3 * DATA_W + 1;
  localparam int DET_W     = 3 * DATA_W + 3;
  localparam int NUM_W     = DET_W + FRAC_BITS + 2;
  localparam int DEN_W     = DET_W + 1;
  localparam int QB        = DATA_W + 1;
  localparam int REM_W     = DEN_W + QB;
  localparam int FRONT     = 6;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [THR_W-1:0] thr_t;
endpackage
`default_nettype wire

[rtl/core/lsc_in_if.sv]
// ----------------------------------------------------------------------------
// lsc_in_if
// Request channel: one 3x3 system and its right-hand side.
// ----------------------------------------------------------------------------
`default_nettype none
interface lsc_in_if;
  logic valid;
  logic ready;
  lsc_pkg::data_t a11, a12, a13, a21, a22, a23, a31, a32, a33;
  lsc_pkg::data_t rhs1, rhs2, rhs3;
  modport source(output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33,
                 rhs1, rhs2, rhs3, input ready);
  modport sink(input valid, a11, a12, a13, a21, a22, a23, a31, a32, a33,
               rhs1, rhs2, rhs3, output ready);
endinterface
`default_nettype wire

[rtl/core/lsc_out_if.sv]
// ----------------------------------------------------------------------------
// lsc_out_if
// Result channel: solution vector and status flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface lsc_out_if;
  logic valid;
  logic ready;
  lsc_pkg::data_t sol1, sol2, sol3;
  logic singular;
  logic overflowed;
  modport source(output valid, sol1, sol2, sol3, singular, overflowed, input ready);
  modport sink(input valid, sol1, sol2, sol3, singular, overflowed, output ready);
endinterface
`default_nettype wire

[rtl/core/linear_solve_3x3_cramer.sv]
// ----------------------------------------------------------------------------
// linear_solve_3x3_cramer
// Solves A x = rhs by Cramer's rule in signed Q16.16, exact determinants,
// rounded quotient, saturation.
// ----------------------------------------------------------------------------
// Pipeline: 6 cofactor/determinant stages, 33 divider stages, one output
// register. Throughput: one request per cycle; a stall at the output holds the
// whole pipeline. Synchronous active-low reset clears the valid bits and sets
// singular_threshold to 1.0 LSB (value 1).
`default_nettype none
module linear_solve_3x3_cramer (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  lsc_in_if.sink                       in_ch,
  lsc_out_if.source                    out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [lsc_pkg::THR_W-1:0] cfg_wdata
);
  localparam int DW     = lsc_pkg::DATA_W;
  localparam int PROD_W = lsc_pkg::PROD_W;
  localparam int CF_W   = lsc_pkg::CF_W;
  localparam int PART_W = lsc_pkg::PART_W;
  localparam int TERM_W = lsc_pkg::TERM_W;
  localparam int DET_W  = lsc_pkg::DET_W;
  localparam int NUM_W  = lsc_pkg::NUM_W;
  localparam int DEN_W  = lsc_pkg::DEN_W;
  localparam int QB     = lsc_pkg::QB;
  localparam int FB     = lsc_pkg::FRAC_BITS;
  localparam int NV     = lsc_pkg::FRONT + QB;

  logic adv;
  lsc_pkg::thr_t thr_r;
  logic [NV-1:0] vp_r;
  logic [QB-1:0] sd_r;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= lsc_pkg::THR_W'(1);
      vp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (adv) begin
        vp_r        <= {vp_r[NV-2:0], in_ch.valid};
        out_valid_r <= vp_r[NV-1];
      end
    end
  end

  // stage 1: minor products
  logic signed [PROD_W-1:0] pa_r [9];
  logic signed [PROD_W-1:0] pb_r [9];
  lsc_pkg::data_t m1_r [6];
  lsc_pkg::data_t m2_r [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r[0] <= in_ch.a22 * in_ch.a33;  pb_r[0] <= in_ch.a23 * in_ch.a32;
      pa_r[1] <= in_ch.a23 * in_ch.a31;  pb_r[1] <= in_ch.a21 * in_ch.a33;
      pa_r[2] <= in_ch.a21 * in_ch.a32;  pb_r[2] <= in_ch.a22 * in_ch.a31;
      pa_r[3] <= in_ch.a13 * in_ch.a32;  pb_r[3] <= in_ch.a12 * in_ch.a33;
      pa_r[4] <= in_ch.a11 * in_ch.a33;  pb_r[4] <= in_ch.a13 * in_ch.a31;
      pa_r[5] <= in_ch.a12 * in_ch.a31;  pb_r[5] <= in_ch.a11 * in_ch.a32;
      pa_r[6] <= in_ch.a12 * in_ch.a23;  pb_r[6] <= in_ch.a13 * in_ch.a22;
      pa_r[7] <= in_ch.a13 * in_ch.a21;  pb_r[7] <= in_ch.a11 * in_ch.a23;
      pa_r[8] <= in_ch.a11 * in_ch.a22;  pb_r[8] <= in_ch.a12 * in_ch.a21;
      m1_r[0] <= in_ch.a11;  m1_r[1] <= in_ch.a21;  m1_r[2] <= in_ch.a31;
      m1_r[3] <= in_ch.rhs1; m1_r[4] <= in_ch.rhs2; m1_r[5] <= in_ch.rhs3;
    end
  end

  // stage 2: cofactors, index (row-1)*3 + (col-1)
  logic signed [CF_W-1:0] cof_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) cof_r[k] <= CF_W'(pa_r[k]) - CF_W'(pb_r[k]);
      for (int k = 0; k < 6; k++) m2_r[k] <= m1_r[k];
    end
  end

  // stage 3: split products; terms 0..2 det, 3+3j+i numerator j
  logic signed [PART_W-1:0] lo_r [12];
  logic signed [PART_W-1:0] hi_r [12];
  lsc_pkg::data_t         tm   [12];
  logic signed [CF_W-1:0] tc   [12];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tm[i] = m2_r[i];
      tc[i] = cof_r[i*3];
      for (int j = 0; j < 3; j++) begin
        tm[3+3*j+i] = m2_r[3+i];
        tc[3+3*j+i] = cof_r[i*3+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 12; t++) begin
        lo_r[t] <= tm[t] * $signed({1'b0, tc[t][DW-1:0]});
        hi_r[t] <= tm[t] * $signed(tc[t][CF_W-1:DW]);
      end
    end
  end

  // stage 4: assemble terms
  logic signed [TERM_W-1:0] term_r [12];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 12; t++)
        term_r[t] <= (TERM_W'(hi_r[t]) <<< DW) + TERM_W'(lo_r[t]);
    end
  end

  // stage 5: determinant and numerators
  logic signed [DET_W-1:0] det_r;
  logic signed [DET_W-1:0] nj_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= DET_W'(term_r[0]) + DET_W'(term_r[1]) + DET_W'(term_r[2]);
      for (int j = 0; j < 3; j++)
        nj_r[j] <= DET_W'(term_r[3+3*j]) + DET_W'(term_r[4+3*j])
                 + DET_W'(term_r[5+3*j]);
    end
  end

  // stage 6: singular test and divider operands
  logic [DET_W-1:0] adet, thr_sh;
  logic [DET_W-1:0] an [3];
  logic sing_r;
  logic [NUM_W-1:0] num_r [3];
  logic [DEN_W-1:0] den_r;
  logic neg_r [3];

  always_comb begin
    adet   = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    thr_sh = DET_W'(thr_r) << (2 * FB);
    for (int j = 0; j < 3; j++)
      an[j] = nj_r[j][DET_W-1] ? DET_W'(-nj_r[j]) : DET_W'(nj_r[j]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= (det_r == '0) || (adet < thr_sh);
      den_r  <= DEN_W'(adet) << 1;
      for (int j = 0; j < 3; j++) begin
        num_r[j] <= (NUM_W'(an[j]) << (FB + 1)) + NUM_W'(adet);
        neg_r[j] <= nj_r[j][DET_W-1] ^ det_r[DET_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) sd_r <= {sd_r[QB-2:0], sing_r};
  end

  // stages 7..39: dividers
  logic [QB-1:0] q   [3];
  logic          big [3];
  logic          qneg [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    lsc_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num_r[j]),
      .den_i (den_r),
      .neg_i (neg_r[j]),
      .q_o   (q[j]),
      .big_o (big[j]),
      .neg_o (qneg[j])
    );
  end

  // output stage: saturate
  logic [QB-1:0] lim [3];
  logic [QB-1:0] mag [3];
  logic          ov  [3];
  lsc_pkg::data_t sol [3];
  lsc_pkg::data_t sol_r [3];
  logic sing_o_r, ovf_o_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lim[j] = qneg[j] ? (QB'(1) << (DW - 1)) : ((QB'(1) << (DW - 1)) - QB'(1));
      ov[j]  = big[j] || (q[j] > lim[j]);
      mag[j] = ov[j] ? lim[j] : q[j];
      sol[j] = qneg[j] ? DW'(-mag[j]) : DW'(mag[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_o_r <= sd_r[QB-1];
      ovf_o_r  <= !sd_r[QB-1] && (ov[0] || ov[1] || ov[2]);
      for (int j = 0; j < 3; j++) sol_r[j] <= sd_r[QB-1] ? '0 : sol[j];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sol1       = sol_r[0];
  assign out_ch.sol2       = sol_r[1];
  assign out_ch.sol3       = sol_r[2];
  assign out_ch.singular   = sing_o_r;
  assign out_ch.overflowed = ovf_o_r;
endmodule
`default_nettype wire

[rtl/core/lsc_div.sv]
// ----------------------------------------------------------------------------
// lsc_div
// Pipelined restoring divider, one quotient bit per stage, with a flag for
// quotients beyond the produced bit count.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [lsc_pkg::NUM_W-1:0] num_i,
  input  wire logic [lsc_pkg::DEN_W-1:0] den_i,
  input  wire logic                      neg_i,
  output logic [lsc_pkg::QB-1:0]         q_o,
  output logic                           big_o,
  output logic                           neg_o
);
  localparam int QB    = lsc_pkg::QB;
  localparam int REM_W = lsc_pkg::REM_W;
  localparam int DEN_W = lsc_pkg::DEN_W;

  logic [REM_W-1:0] rem_r [QB];
  logic [DEN_W-1:0] den_r [QB];
  logic [QB-1:0]    q_r   [QB];
  logic             big_r [QB];
  logic             neg_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_st
    localparam int K = QB - 1 - s;
    logic [REM_W-1:0] rin, dsh;
    logic [DEN_W-1:0] din;
    logic [QB-1:0]    qin;
    logic             bin, nin;
    if (s == 0) begin : g_first
      assign rin = REM_W'(num_i);
      assign din = den_i;
      assign qin = '0;
      assign nin = neg_i;
      assign bin = REM_W'(num_i) >= (REM_W'(den_i) << QB);
    end else begin : g_rest
      assign rin = rem_r[s-1];
      assign din = den_r[s-1];
      assign qin = q_r[s-1];
      assign nin = neg_r[s-1];
      assign bin = big_r[s-1];
    end
    assign dsh = REM_W'(din) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= dsh) begin
          rem_r[s] <= rin - dsh;
          q_r[s]   <= qin | (QB'(1) << K);
        end else begin
          rem_r[s] <= rin;
          q_r[s]   <= qin;
        end
        den_r[s] <= din;
        big_r[s] <= bin;
        neg_r[s] <= nin;
      end
    end
  end

  assign q_o   = q_r[QB-1];
  assign big_o = big_r[QB-1];
  assign neg_o = neg_r[QB-1];
endmodule
`default_nettype wire

[sim/tb_linear_solve_3x3_cramer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_solve_3x3_cramer
// Drives 3x3 systems into the Cramer's rule solver under random idling and
// output stalls, over several singular thresholds. Each result is checked field
// by field in order against a directed value or an exact wide-integer solver.
// ----------------------------------------------------------------------------
module tb_linear_solve_3x3_cramer;
  typedef lsc_pkg::data_t data_t;
  typedef lsc_pkg::thr_t  thr_t;

  localparam int THR_W      = lsc_pkg::THR_W;
  localparam int FRAC_BITS  = lsc_pkg::FRAC_BITS;
  localparam int WW         = 160;
  localparam int LIMIT      = 600000;
  localparam int N_PHASE    = 5;
  localparam int PER_PHASE  = 230;
  localparam int DRAIN_WAIT = 50;
  localparam int N_DIR      = 16;

  typedef logic signed [WW-1:0] wide_t;
  typedef data_t mat_t [9];
  typedef data_t vec_t [3];

  typedef struct {
    data_t sol1, sol2, sol3;
    logic  singular;
    logic  overflowed;
  } soln_t;

  typedef struct {
    mat_t  a;
    vec_t  b;
    bit    known;
    soln_t want;
  } dir_row_t;

  localparam data_t DMAX = 32'sh7fffffff;
  localparam data_t DMIN = 32'sh80000000;
  localparam data_t ONE  = 32'sh00010000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  thr_t cfg_wdata = '0;

  lsc_in_if  in_ch();
  lsc_out_if out_ch();

  linear_solve_3x3_cramer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  thr_t  thr_shadow = thr_t'(1);
  soln_t sol_q[$];
  int    fails = 0;
  int    cycles = 0;
  bit    calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic wide_t det3(wide_t e[9]);
    return e[0] * (e[4] * e[8] - e[7] * e[5])
         - e[3] * (e[1] * e[8] - e[7] * e[2])
         + e[6] * (e[1] * e[5] - e[4] * e[2]);
  endfunction

  function automatic soln_t solve_cramer(mat_t a, vec_t b, thr_t thr);
    wide_t e[9], c[9];
    wide_t d, ad, nd, an, tw, num, q, lim;
    logic  neg;
    soln_t s;
    data_t x[3];
    s = '{default: '0};
    for (int i = 0; i < 9; i++) e[i] = a[i];
    d = det3(e);
    ad = (d < 0) ? -d : d;
    tw = '0;
    tw[THR_W-1:0] = thr;
    tw = tw <<< 32;
    if (d == 0 || ad < tw) begin
      s.singular = 1'b1;
      return s;
    end
    for (int j = 0; j < 3; j++) begin
      c = e;
      for (int i = 0; i < 3; i++) c[i*3+j] = b[i];
      nd = det3(c);
      neg = (nd < 0) != (d < 0);
      an = (nd < 0) ? -nd : nd;
      num = (an <<< (FRAC_BITS + 1)) + ad;
      q = num / (ad <<< 1);
      lim = neg ? (wide_t'(1) <<< 31) : (wide_t'(1) <<< 31) - 1;
      if (q > lim) begin
        q = lim;
        s.overflowed = 1'b1;
      end
      x[j] = neg ? -data_t'(q[31:0]) : data_t'(q[31:0]);
    end
    s.sol1 = x[0];
    s.sol2 = x[1];
    s.sol3 = x[2];
    return s;
  endfunction

  function automatic mat_t diag(data_t d1, data_t d2, data_t d3);
    mat_t m;
    m = '{default: '0};
    m[0] = d1;
    m[4] = d2;
    m[8] = d3;
    return m;
  endfunction

  function automatic data_t rnd_small();
    return data_t'(int'($urandom_range(0, 524288)) - 262144);
  endfunction

  function automatic data_t rnd_edge();
    case ($urandom_range(0, 4))
      0: return DMAX;
      1: return DMIN;
      2: return '0;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic gen_random(output mat_t a, output vec_t b);
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) b[i] = data_t'($urandom);
    case (mode)
      0, 1, 2: for (int i = 0; i < 9; i++) a[i] = data_t'($urandom);
      3, 4, 5: begin
        for (int i = 0; i < 9; i++) a[i] = rnd_small();
        for (int i = 0; i < 3; i++) b[i] = rnd_small();
      end
      6, 7: begin
        for (int i = 0; i < 6; i++) a[i] = rnd_small();
        for (int i = 0; i < 3; i++)
          a[6+i] = a[i] + a[3+i] + data_t'(int'($urandom_range(0, 4)) - 2);
      end
      8: begin
        a = diag(data_t'($urandom_range(1, 32'h2000)), data_t'($urandom_range(1, 32'h2000)),
                 data_t'($urandom_range(1, 32'h2000)));
        if ($urandom_range(0, 1)) a[0] = -a[0];
      end
      default: begin
        for (int i = 0; i < 9; i++) a[i] = rnd_edge();
        for (int i = 0; i < 3; i++) b[i] = rnd_edge();
      end
    endcase
  endtask

  task automatic send_request(mat_t a, vec_t b, bit known, soln_t want);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a11 <= a[0]; in_ch.a12 <= a[1]; in_ch.a13 <= a[2];
    in_ch.a21 <= a[3]; in_ch.a22 <= a[4]; in_ch.a23 <= a[5];
    in_ch.a31 <= a[6]; in_ch.a32 <= a[7]; in_ch.a33 <= a[8];
    in_ch.rhs1 <= b[0]; in_ch.rhs2 <= b[1]; in_ch.rhs3 <= b[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sol_q.push_back(known ? want : solve_cramer(a, b, thr_shadow));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sol_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(thr_t v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_shadow = v;
  endtask

  // result sink: random stalls
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    soln_t exp_s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sol_q.size() == 0) begin
        $error("unexpected result sol1=%h", out_ch.sol1);
        fails++;
      end else begin
        exp_s = sol_q.pop_front();
        if (out_ch.sol1 !== exp_s.sol1) begin
          $error("sol1 exp %h got %h", exp_s.sol1, out_ch.sol1); fails++;
        end
        if (out_ch.sol2 !== exp_s.sol2) begin
          $error("sol2 exp %h got %h", exp_s.sol2, out_ch.sol2); fails++;
        end
        if (out_ch.sol3 !== exp_s.sol3) begin
          $error("sol3 exp %h got %h", exp_s.sol3, out_ch.sol3); fails++;
        end
        if (out_ch.singular !== exp_s.singular) begin
          $error("singular exp %b got %b", exp_s.singular, out_ch.singular); fails++;
        end
        if (out_ch.overflowed !== exp_s.overflowed) begin
          $error("overflowed exp %b got %b", exp_s.overflowed, out_ch.overflowed); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL linear_solve_3x3_cramer");
      $finish;
    end
  end

  dir_row_t dir_tab [N_DIR];
  soln_t    sing_s;

  initial begin
    mat_t  a;
    vec_t  b;
    soln_t none;
    thr_t  thr_list [N_PHASE];

    none = '{default: '0};
    sing_s = '{sol1: '0, sol2: '0, sol3: '0, singular: 1'b1, overflowed: 1'b0};
    foreach (dir_tab[i]) begin
      dir_tab[i].known = 1'b0;
      dir_tab[i].want = none;
      dir_tab[i].b = '{default: '0};
    end
    // identity: solution equals rhs
    dir_tab[0].a = diag(ONE, ONE, ONE);  dir_tab[0].b = '{DMAX, DMIN, 32'sh1};
    dir_tab[0].known = 1'b1;
    dir_tab[0].want = '{sol1: DMAX, sol2: DMIN, sol3: 32'sh1, singular: 1'b0, overflowed: 1'b0};
    dir_tab[1].a = '{default: '0};       dir_tab[1].b = '{DMAX, DMAX, DMAX};
    dir_tab[1].known = 1'b1;             dir_tab[1].want = sing_s;
    dir_tab[2].a = '{default: DMAX};     dir_tab[2].b = '{DMAX, DMIN, DMAX};
    dir_tab[2].known = 1'b1;             dir_tab[2].want = sing_s;
    dir_tab[3].a = '{default: DMIN};     dir_tab[3].b = '{DMIN, DMIN, DMIN};
    dir_tab[3].known = 1'b1;             dir_tab[3].want = sing_s;
    // tiny determinant below threshold
    dir_tab[4].a = diag(32'sh1, 32'sh1, 32'sh1); dir_tab[4].b = '{ONE, ONE, ONE};
    dir_tab[4].known = 1'b1;             dir_tab[4].want = sing_s;
    // small pivots, large rhs: saturation both ways
    dir_tab[5].a = diag(32'sh1000, 32'sh1000, 32'sh1000); dir_tab[5].b = '{DMAX, DMIN, ONE};
    dir_tab[6].a = diag(-32'sh1000, 32'sh1000, 32'sh1000); dir_tab[6].b = '{DMAX, DMAX, DMIN};
    dir_tab[7].a = diag(-ONE, -ONE, -ONE); dir_tab[7].b = '{DMIN, DMAX, 32'sh0};
    // rounding: 1/3 and ties
    dir_tab[8].a = diag(3 * ONE, 2 * ONE, -2 * ONE); dir_tab[8].b = '{ONE, 32'sh1, 32'sh3};
    dir_tab[9].a = '{DMAX, DMIN, 32'sh0, DMIN, DMAX, DMAX, 32'sh0, DMAX, DMIN};
    dir_tab[9].b = '{DMAX, DMIN, DMAX};
    dir_tab[10].a = '{DMIN, 32'sh0, 32'sh0, 32'sh0, DMIN, 32'sh0, 32'sh0, 32'sh0, DMIN};
    dir_tab[10].b = '{DMIN, DMAX, 32'sh1};
    dir_tab[11].a = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
                      10 * ONE};
    dir_tab[11].b = '{ONE, -ONE, 32'sh7};
    dir_tab[12].a = '{32'sh0, ONE, 32'sh0, ONE, 32'sh0, 32'sh0, 32'sh0, 32'sh0, ONE};
    dir_tab[12].b = '{32'sh5, -32'sh5, DMAX};
    dir_tab[13].a = '{32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678, 32'sh7fff0000,
                      32'sh8000ffff, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh00ff00ff};
    dir_tab[13].b = '{32'sh5555aaaa, 32'shaaaa5555, 32'shffffffff};
    dir_tab[14].a = diag(32'sh100, 32'sh100, 32'sh100); dir_tab[14].b = '{ONE, ONE, ONE};
    dir_tab[15].a = diag(DMAX, DMAX, DMAX); dir_tab[15].b = '{DMAX, DMIN, 32'sh1};

    thr_list[0] = 31'h0;
    thr_list[1] = 31'h7fffffff;
    thr_list[2] = thr_t'($urandom);
    thr_list[3] = thr_t'($urandom_range(1, 32'h30000));
    thr_list[4] = thr_t'(1);

    in_ch.valid <= 1'b0;
    {in_ch.a11, in_ch.a12, in_ch.a13, in_ch.a21, in_ch.a22, in_ch.a23} <= '0;
    {in_ch.a31, in_ch.a32, in_ch.a33, in_ch.rhs1, in_ch.rhs2, in_ch.rhs3} <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_tab[i].a, dir_tab[i].b, dir_tab[i].known, dir_tab[i].want);
    drain();
    write_threshold(thr_t'(0));
    for (int i = 4; i < N_DIR; i++) send_request(dir_tab[i].a, dir_tab[i].b, 1'b0, none);

    for (int p = 0; p < N_PHASE; p++) begin
      drain();
      write_threshold(thr_list[p]);
      for (int n = 0; n < PER_PHASE; n++) begin
        calm = (p == 2 && n >= 60 && n < 160);
        if (p == 1 && n == PER_PHASE / 2) begin
          in_ch.valid <= 1'b0;
          while (sol_q.size() != 0) @(posedge clk);
        end
        gen_random(a, b);
        send_request(a, b, 1'b0, none);
      end
      calm = 1'b0;
    end
    drain();
    if (fails == 0) begin
      $display("PASS linear_solve_3x3_cramer");
    end else begin
      $display("FAIL linear_solve_3x3_cramer");
    end
    $finish;
  end
endmodule
